@@ sv/cwtm_pkg.sv @@
// Shared types, constants and table builders for the CW transition matrix core.
`timescale 1ns / 1ps
package cwtm_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int OUT_FRAC_BITS = 32;
  localparam int ATAN_ENTRIES  = 48;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int IDX_W         = $clog2(ATAN_ENTRIES);
  localparam int RED_BITS      = 64;
  localparam int DIV_BITS      = 128;
  localparam int NUM_LANES     = 3;
  localparam int LANE_SIN      = 0;
  localparam int LANE_VERS     = 1;
  localparam int LANE_SIN4     = 2;
  localparam int NUM_ROWS      = 6;
  localparam int ROW_W         = 3;
  localparam int RND_SHIFT     = 92 - OUT_FRAC_BITS;
  localparam int OUT_TDATA_W   = 392;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

  // Register indexes (byte address bit 2)
  localparam logic REG_IDX_MEAN_MOTION = 1'b0;
  localparam logic [31:0] MEAN_MOTION_RST = 32'd4846870;

  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] INV_GAIN_Q60 = 64'd700114967507363026;
  localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;
  localparam logic [63:0] RED_STEP    = 64'h0000000000100000;

  typedef logic [ATAN_ENTRIES-1:0][63:0] atan_tab_t;

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] t;
    logic [31:0] d;
  } red_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic               flip;
    logic [31:0]        d;
  } cor_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][31:0]  rem;
    logic [NUM_LANES-1:0][127:0] acc;
    logic [63:0]                 c;
    logic [63:0]                 s;
    logic [63:0]                 ms;
    logic [63:0]                 mc;
    logic                        sgn_s;
    logic                        sgn_oc;
    logic [31:0]                 d;
  } div_t;

  typedef struct packed {
    logic [NUM_ROWS-1:0][NUM_ROWS-1:0][63:0] ent;
    logic [NUM_ROWS-1:0]                     ovf;
  } mat_t;

  // Shift-subtract quotient, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    int          b;
    rem = '0;
    q   = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent series per stage, Q60
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] acc;
    logic [63:0] term;
    int          i;
    int          k;
    int          e;
    tab    = '0;
    tab[0] = TWO_PI_Q60 >> 3;
    for (i = 1; i < ATAN_ENTRIES; i++) begin
      acc = '0;
      for (k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = udiv64(64'd1 << e, 64'(2 * k + 1));
          if ((k & 1) == 0) begin
            acc = acc + term;
          end else begin
            acc = acc - term;
          end
        end
      end
      tab[i] = (acc + 64'd2) >> 2;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

@@ sv/cw_transition_matrix_core.sv @@
// Top level: Clohessy-Wiltshire state transition matrix generator.
`timescale 1ns / 1ps
//
//  channel   | dir | beats per request      | contents
//  ----------+-----+------------------------+-------------------------------------
//  s_axis    | in  | 1                      | step time dt (2^-8 s)
//  m_axis    | out | 6 (rows 0..5, tlast=5) | row index, six Q32.32 entries, ovf
//  apb       | in  | setup + access         | mean motion n at byte address 0
//
//  Every step time request gives six row results, one per cycle while m_axis_tready
//  is high, so in steady state a new request is taken as the last row of the previous
//  matrix leaves; the output row sequencer sets the pace. The first row follows the
//  request via one register each: 1 multiply, 64 reduction cells, 2 fold stages, 32
//  CORDIC cells, 2 setup stages, 128 divider cells and 7 product, assembly and rounding
//  stages. The whole cell chain advances as one; it holds while the finished matrix
//  waits for its last row to be taken. Reset clears valid bits and sets n to 4846870.
module cw_transition_matrix_core import cwtm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // s_axis_tdata: [31:0] step_time
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,
  // m_axis_tdata: [2:0] row_index, [66:3] col_radial, [130:67] col_along,
  //   [194:131] col_cross, [258:195] col_radial_rate, [322:259] col_along_rate,
  //   [386:323] col_cross_rate, [391:387] zero
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // m_axis_tuser: [0] overflow
  output logic [0:0]             m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [31:0] mean_motion_q;
  logic        adv;
  logic        f_valid;
  mat_t        mat;
  logic [ROW_W-1:0] row_q;

  // User must change n only while idle (not enforced), so every stage reads it live
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_motion_q <= MEAN_MOTION_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MEAN_MOTION)) begin
      mean_motion_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_IDX_MEAN_MOTION) ? mean_motion_q : 32'd0;
  assign pready = 1'b1;

  // Advance the chain when the output holds nothing or its last row leaves now
  assign adv           = !f_valid || (m_axis_tready && (row_q == ROW_LAST));
  assign s_axis_tready = adv;

  // Stage 0: t = n * dt, angle in units of 2^-40 rad
  logic st0_v_q;
  red_t st0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st0_v_q <= 1'b0;
    end else if (adv) begin
      st0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q.r <= '0;
      st0_q.t <= {32'd0, s_axis_tdata} * {32'd0, mean_motion_q};
      st0_q.d <= s_axis_tdata;
    end
  end

  // Reduction chain: one bit of t per cell, MSB first
  red_t red_c [RED_BITS+1];
  logic red_v [RED_BITS+1];

  assign red_c[0] = st0_q;
  assign red_v[0] = st0_v_q;

  for (genvar g = 0; g < RED_BITS; g++) begin : g_red
    cwtm_red_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (red_v[g]),
      .data_i  (red_c[g]),
      .valid_o (red_v[g+1]),
      .data_o  (red_c[g+1])
    );
  end

  // Fold 1: move the remainder into [-pi, pi) and seed the CORDIC vector
  logic        fa_v_q;
  cor_t        fa_q;
  logic [63:0] r_in;

  assign r_in = red_c[RED_BITS].r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_v_q <= 1'b0;
    end else if (adv) begin
      fa_v_q <= red_v[RED_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q.x    <= $signed(INV_GAIN_Q60);
      fa_q.y    <= '0;
      fa_q.z    <= (r_in >= PI_Q60) ? $signed(r_in - TWO_PI_Q60) : $signed(r_in);
      fa_q.flip <= 1'b0;
      fa_q.d    <= red_c[RED_BITS].d;
    end
  end

  // Fold 2: into [-pi/2, pi/2], remember the sign flip
  logic fb_v_q;
  cor_t fb_q;
  cor_t fb_d;

  always_comb begin
    fb_d = fa_q;
    if (fa_q.z > $signed(HALF_PI_Q60)) begin
      fb_d.z    = fa_q.z - $signed(PI_Q60);
      fb_d.flip = 1'b1;
    end else if (fa_q.z < -$signed(HALF_PI_Q60)) begin
      fb_d.z    = fa_q.z + $signed(PI_Q60);
      fb_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_v_q <= 1'b0;
    end else if (adv) begin
      fb_v_q <= fa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fb_q <= fb_d;
    end
  end

  // CORDIC chain
  cor_t cor_c [CORDIC_RUN+1];
  logic cor_v [CORDIC_RUN+1];

  assign cor_c[0] = fb_q;
  assign cor_v[0] = fb_v_q;

  for (genvar g = 0; g < CORDIC_RUN; g++) begin : g_cor
    cwtm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .idx_i   (IDX_W'(g)),
      .valid_i (cor_v[g]),
      .data_i  (cor_c[g]),
      .valid_o (cor_v[g+1]),
      .data_o  (cor_c[g+1])
    );
  end

  // Post A: undo the fold on cos and sin
  logic        pa_v_q;
  logic [63:0] pa_c_q, pa_s_q;
  logic [31:0] pa_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_v_q <= 1'b0;
    end else if (adv) begin
      pa_v_q <= cor_v[CORDIC_RUN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_c_q <= cor_c[CORDIC_RUN].flip ? -cor_c[CORDIC_RUN].x : cor_c[CORDIC_RUN].x;
      pa_s_q <= cor_c[CORDIC_RUN].flip ? -cor_c[CORDIC_RUN].y : cor_c[CORDIC_RUN].y;
      pa_d_q <= cor_c[CORDIC_RUN].d;
    end
  end

  // Post B: magnitudes for the dividers and the n products
  div_t        pb_d;
  div_t        pb_q;
  logic        pb_v_q;
  logic [63:0] oc;

  always_comb begin
    oc          = ONE_Q60 - pa_c_q;
    pb_d.c      = pa_c_q;
    pb_d.s      = pa_s_q;
    pb_d.sgn_s  = pa_s_q[63];
    pb_d.sgn_oc = oc[63];
    pb_d.ms     = pa_s_q[63] ? -pa_s_q : pa_s_q;
    pb_d.mc     = oc[63] ? -oc : oc;
    pb_d.d      = pa_d_q;
    pb_d.rem    = '0;
    pb_d.acc[LANE_SIN]  = {pb_d.ms, 64'd0};
    pb_d.acc[LANE_VERS] = {pb_d.mc[62:0], 1'b0, 64'd0};
    pb_d.acc[LANE_SIN4] = {pb_d.ms[61:0], 2'b00, 64'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_v_q <= 1'b0;
    end else if (adv) begin
      pb_v_q <= pa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pb_q <= pb_d;
    end
  end

  // Divider chain: one quotient bit per cell in every lane
  div_t div_c [DIV_BITS+1];
  logic div_v [DIV_BITS+1];

  assign div_c[0] = pb_q;
  assign div_v[0] = pb_v_q;

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    cwtm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .n_i     (mean_motion_q),
      .valid_i (div_v[g]),
      .data_i  (div_c[g]),
      .valid_o (div_v[g+1]),
      .data_o  (div_c[g+1])
    );
  end

  cwtm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .n_i     (mean_motion_q),
    .valid_i (div_v[DIV_BITS]),
    .data_i  (div_c[DIV_BITS]),
    .valid_o (f_valid),
    .mat_o   (mat)
  );

  // Row sequencer: restart on every new matrix, step on each taken row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (adv) begin
      row_q <= '0;
    end else if (m_axis_tready) begin
      row_q <= row_q + ROW_W'(1);
    end
  end

  assign m_axis_tvalid   = f_valid;
  assign m_axis_tdata    = {5'd0, mat.ent[row_q][5], mat.ent[row_q][4], mat.ent[row_q][3],
                            mat.ent[row_q][2], mat.ent[row_q][1], mat.ent[row_q][0], row_q};
  assign m_axis_tlast    = (row_q == ROW_LAST);
  assign m_axis_tuser[0] = mat.ovf[row_q];

endmodule

@@ sv/cwtm_red_cell.sv @@
// One bit of the modulo 2*pi angle reduction chain.
`timescale 1ns / 1ps
module cwtm_red_cell import cwtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  red_t data_i,
  output logic valid_o,
  output red_t data_o
);

  logic        valid_q;
  red_t        data_q;
  red_t        data_d;
  logic [63:0] r2;

  always_comb begin
    r2 = {data_i.r[62:0], 1'b0} + (data_i.t[63] ? RED_STEP : 64'd0);
    data_d   = data_i;
    data_d.r = (r2 >= TWO_PI_Q60) ? r2 - TWO_PI_Q60 : r2;
    data_d.t = {data_i.t[62:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/cwtm_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation.
`timescale 1ns / 1ps
module cwtm_cordic_cell import cwtm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             valid_i,
  input  cor_t             data_i,
  output logic             valid_o,
  output cor_t             data_o
);

  logic               valid_q;
  cor_t               data_q;
  cor_t               data_d;
  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [63:0] at;

  always_comb begin
    dx     = data_i.y >>> idx_i;
    dy     = data_i.x >>> idx_i;
    at     = $signed(ATAN_TAB[idx_i]);
    data_d = data_i;
    if (data_i.z >= 0) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/cwtm_div_cell.sv @@
// One restoring quotient bit for each of the three divide-by-n lanes.
`timescale 1ns / 1ps
module cwtm_div_cell import cwtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [31:0] n_i,
  input  logic        valid_i,
  input  div_t        data_i,
  output logic        valid_o,
  output div_t        data_o
);

  logic        valid_q;
  div_t        data_q;
  div_t        data_d;
  logic [32:0] tmp [NUM_LANES];
  logic [31:0] nr  [NUM_LANES];
  logic        ge  [NUM_LANES];

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      tmp[l] = {data_i.rem[l], data_i.acc[l][127]};
      ge[l]  = tmp[l] >= {1'b0, n_i};
      // remainder stays below n, so it always fits in 32 bits
      nr[l]  = ge[l] ? 32'(tmp[l] - {1'b0, n_i}) : tmp[l][31:0];
      data_d.rem[l] = nr[l];
      data_d.acc[l] = {data_i.acc[l][126:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/cwtm_matrix.sv @@
// Products by n, matrix entry assembly, rounding and saturation stages.
`timescale 1ns / 1ps
module cwtm_matrix import cwtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [31:0] n_i,
  input  logic        valid_i,
  input  div_t        data_i,
  output logic        valid_o,
  output mat_t        mat_o
);

  localparam logic [127:0] ONE_Q92   = 128'd1 << 92;
  localparam logic [127:0] THREE_Q92 = 128'd3 << 92;
  localparam logic [127:0] RND_HALF  = 128'd1 << (RND_SHIFT - 1);
  localparam logic [127:0] SAT_POS   = (128'd1 << 63) - 128'd1;
  localparam logic [127:0] SAT_NEG   = 128'd1 << 63;

  typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][127:0] ent_arr_t;
  typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0]        flag_arr_t;

  function automatic logic [127:0] q92(input logic [63:0] v);
    return {{32{v[63]}}, v, 32'd0};
  endfunction

  logic [6:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // M1: sign quotients, partial products, t and 3*dt
  logic [NUM_LANES-1:0][127:0] q1_d, q1_q;
  logic [63:0] ps_lo_q, ps_hi_q, pc_lo_q, pc_hi_q, t1_q, c1_q, s1_q;
  logic [33:0] d3_1_q;
  logic        sgn_s1_q, sgn_oc1_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (n_i == '0) begin
        q1_d[l] = '0;
      end else if ((l == LANE_VERS) ? data_i.sgn_oc : data_i.sgn_s) begin
        q1_d[l] = -data_i.acc[l];
      end else begin
        q1_d[l] = data_i.acc[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q1_q      <= q1_d;
      ps_lo_q   <= {32'd0, data_i.ms[31:0]} * {32'd0, n_i};
      ps_hi_q   <= {32'd0, data_i.ms[63:32]} * {32'd0, n_i};
      pc_lo_q   <= {32'd0, data_i.mc[31:0]} * {32'd0, n_i};
      pc_hi_q   <= {32'd0, data_i.mc[63:32]} * {32'd0, n_i};
      t1_q      <= {32'd0, data_i.d} * {32'd0, n_i};
      d3_1_q    <= {2'd0, data_i.d} + {1'b0, data_i.d, 1'b0};
      c1_q      <= data_i.c;
      s1_q      <= data_i.s;
      sgn_s1_q  <= data_i.sgn_s;
      sgn_oc1_q <= data_i.sgn_oc;
    end
  end

  // M2: product magnitudes and the secular term s - t
  logic [NUM_LANES-1:0][127:0] q2_q;
  logic [127:0] sn_mag_q, cn_mag_q, u2_q;
  logic [63:0]  c2_q, s2_q;
  logic [33:0]  d3_2_q;
  logic         sgn_s2_q, sgn_oc2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q2_q      <= q1_q;
      sn_mag_q  <= {64'd0, ps_lo_q} + {32'd0, ps_hi_q, 32'd0};
      cn_mag_q  <= {64'd0, pc_lo_q} + {32'd0, pc_hi_q, 32'd0};
      u2_q      <= q92(s1_q) - {12'd0, t1_q, 52'd0};
      c2_q      <= c1_q;
      s2_q      <= s1_q;
      d3_2_q    <= d3_1_q;
      sgn_s2_q  <= sgn_s1_q;
      sgn_oc2_q <= sgn_oc1_q;
    end
  end

  // M3: apply signs of n*s and n*(c-1)
  logic [NUM_LANES-1:0][127:0] q3_q;
  logic [127:0] sn_q, cn_q, u3_q;
  logic [63:0]  c3_q, s3_q;
  logic [33:0]  d3_3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q3_q   <= q2_q;
      sn_q   <= sgn_s2_q ? -sn_mag_q : sn_mag_q;
      cn_q   <= sgn_oc2_q ? cn_mag_q : -cn_mag_q;
      u3_q   <= u2_q;
      c3_q   <= c2_q;
      s3_q   <= s2_q;
      d3_3_q <= d3_2_q;
    end
  end

  // E: exact entries in Q92
  ent_arr_t     ent_d, ent_q;
  logic [127:0] cw, sw;

  always_comb begin
    cw    = q92(c3_q);
    sw    = q92(s3_q);
    ent_d = '0;
    ent_d[0][0] = (ONE_Q92 << 2) - cw - (cw << 1);
    ent_d[0][3] = q3_q[LANE_SIN];
    ent_d[0][4] = q3_q[LANE_VERS];
    ent_d[1][0] = (u3_q << 2) + (u3_q << 1);
    ent_d[1][1] = ONE_Q92;
    ent_d[1][3] = -q3_q[LANE_VERS];
    ent_d[1][4] = q3_q[LANE_SIN4] - {10'd0, d3_3_q, 84'd0};
    ent_d[2][2] = cw;
    ent_d[2][5] = q3_q[LANE_SIN];
    ent_d[3][0] = sn_q + (sn_q << 1);
    ent_d[3][3] = cw;
    ent_d[3][4] = sw << 1;
    ent_d[4][0] = (cn_q << 2) + (cn_q << 1);
    ent_d[4][3] = -(sw << 1);
    ent_d[4][4] = (cw << 2) - THREE_Q92;
    ent_d[5][2] = -sn_q;
    ent_d[5][5] = cw;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ent_q <= ent_d;
    end
  end

  // F1: magnitude, F2: round half away, F3: saturate and restore sign
  ent_arr_t  mag_d, mag_q, rnd_d, rnd_q;
  flag_arr_t neg1_q, neg2_q, ovf_d;
  logic [NUM_ROWS-1:0][NUM_ROWS-1:0][63:0] sat_v, out_d;
  logic [NUM_ROWS-1:0] row_ovf_d;

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int j = 0; j < NUM_ROWS; j++) begin
        mag_d[i][j] = ent_q[i][j][127] ? -ent_q[i][j] : ent_q[i][j];
        rnd_d[i][j] = (mag_q[i][j] + RND_HALF) >> RND_SHIFT;
        ovf_d[i][j] = rnd_q[i][j] > (neg2_q[i][j] ? SAT_NEG : SAT_POS);
        sat_v[i][j] = ovf_d[i][j] ? (neg2_q[i][j] ? SAT_NEG[63:0] : SAT_POS[63:0])
                                  : rnd_q[i][j][63:0];
        out_d[i][j] = neg2_q[i][j] ? -sat_v[i][j] : sat_v[i][j];
      end
      row_ovf_d[i] = |ovf_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag_q  <= mag_d;
      neg1_q <= {ent_q[5][5][127], ent_q[5][4][127], ent_q[5][3][127], ent_q[5][2][127],
                 ent_q[5][1][127], ent_q[5][0][127],
                 ent_q[4][5][127], ent_q[4][4][127], ent_q[4][3][127], ent_q[4][2][127],
                 ent_q[4][1][127], ent_q[4][0][127],
                 ent_q[3][5][127], ent_q[3][4][127], ent_q[3][3][127], ent_q[3][2][127],
                 ent_q[3][1][127], ent_q[3][0][127],
                 ent_q[2][5][127], ent_q[2][4][127], ent_q[2][3][127], ent_q[2][2][127],
                 ent_q[2][1][127], ent_q[2][0][127],
                 ent_q[1][5][127], ent_q[1][4][127], ent_q[1][3][127], ent_q[1][2][127],
                 ent_q[1][1][127], ent_q[1][0][127],
                 ent_q[0][5][127], ent_q[0][4][127], ent_q[0][3][127], ent_q[0][2][127],
                 ent_q[0][1][127], ent_q[0][0][127]};
      rnd_q  <= rnd_d;
      neg2_q <= neg1_q;
      mat_o.ent <= out_d;
      mat_o.ovf <= row_ovf_d;
    end
  end

  assign valid_o = v_q[6];

endmodule

@@ tb/cwtm_checker.sv @@
// Scoreboard for the CW transition matrix core: predicts the rows of each request and compares.
`timescale 1ns / 1ps
module cwtm_checker import cwtm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tlast,
  input  logic [0:0]             m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     mismatch_cnt_o,
  output int                     rows_pending_o
);

  typedef struct {
    logic [2:0]  row;
    logic [63:0] col [6];
    logic        last;
    logic        ovf;
  } stm_row_t;

  stm_row_t    rows_due [$];
  logic [31:0] mean_motion_q;
  longint      arc_tab [ATAN_ENTRIES];
  int          mismatches;

  assign mismatch_cnt_o = mismatches;
  assign rows_pending_o = rows_due.size();

  initial begin
    logic [63:0] acc;
    int          e;
    mismatches = 0;
    arc_tab[0] = longint'(TWO_PI_Q60 >> 3);
    for (int i = 1; i < ATAN_ENTRIES; i++) begin
      acc = '0;
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          if ((k & 1) == 0) acc = acc + (64'd1 << e) / 64'(2 * k + 1);
          else acc = acc - (64'd1 << e) / 64'(2 * k + 1);
        end
      end
      arc_tab[i] = longint'((acc + 64'd2) >> 2);
    end
  end

  function automatic logic [127:0] sext(input logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

  function automatic logic [127:0] over_n(input logic [63:0] v, input logic [31:0] n);
    logic [63:0]  mag;
    logic [127:0] q;
    if (n == 0) return '0;
    mag = v[63] ? -v : v;
    q   = {mag, 64'd0} / {96'd0, n};
    return v[63] ? -q : q;
  endfunction

  function automatic logic [127:0] times_n(input logic [63:0] v, input logic [31:0] n);
    logic [63:0]  mag;
    logic [127:0] q;
    mag = v[63] ? -v : v;
    q   = {64'd0, mag} * {96'd0, n};
    return v[63] ? -q : q;
  endfunction

  // Round half away from zero to OUT_FRAC_BITS, saturate to 64 bits
  function automatic logic [63:0] round_sat(input logic [127:0] w, inout logic ovf);
    logic         neg;
    logic [127:0] m;
    logic [63:0]  lim;
    neg = w[127];
    m   = neg ? -w : w;
    lim = neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    m   = (m + (128'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    if (m[127:64] != 0 || m[63:0] > lim) begin
      ovf = 1'b1;
      m   = {64'd0, lim};
    end
    return neg ? -m[63:0] : m[63:0];
  endfunction

  task automatic predict_matrix(input logic [31:0] d);
    logic [31:0]  n;
    logic [63:0]  t;
    logic [63:0]  r;
    longint       x, y, z, dx, dy;
    logic         flip;
    logic [63:0]  c, s;
    logic [127:0] m [6][6];
    logic [127:0] cw, sw, one, q;
    stm_row_t     row;
    n = mean_motion_q;
    t = {32'd0, n} * {32'd0, d};
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) + (t[b] ? RED_STEP : 64'd0);
      if (r >= TWO_PI_Q60) r = r - TWO_PI_Q60;
    end
    // fold into [-pi/2, pi/2]
    z = longint'(r);
    if (r >= PI_Q60) z = longint'(r - TWO_PI_Q60);
    flip = 1'b0;
    if (z > longint'(HALF_PI_Q60)) begin
      z = z - longint'(PI_Q60);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q60)) begin
      z = z + longint'(PI_Q60);
      flip = 1'b1;
    end
    x = longint'(INV_GAIN_Q60);
    y = 0;
    for (int i = 0; i < CORDIC_RUN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arc_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + arc_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;

    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++) m[i][j] = '0;
    cw  = sext(c) << 32;
    sw  = sext(s) << 32;
    one = 128'd1 << 92;
    m[0][0] = (one << 2) - 3 * cw;
    m[1][0] = 6 * (sw - ({64'd0, t} << 52));
    m[1][1] = one;
    m[2][2] = cw;
    m[0][3] = over_n(s, n);
    q       = over_n(64'd2 * (ONE_Q60 - c), n);
    m[0][4] = q;
    m[1][3] = -q;
    m[1][4] = over_n(64'd4 * s, n) - 3 * ({96'd0, d} << 84);
    m[2][5] = m[0][3];
    m[3][0] = 3 * times_n(s, n);
    m[4][0] = 6 * times_n(c - ONE_Q60, n);
    m[5][2] = -times_n(s, n);
    m[3][3] = cw;
    m[3][4] = sw << 1;
    m[4][3] = -(sw << 1);
    m[4][4] = (cw << 2) - 3 * one;
    m[5][5] = cw;

    for (int i = 0; i < 6; i++) begin
      row.row  = 3'(i);
      row.ovf  = 1'b0;
      for (int j = 0; j < 6; j++) row.col[j] = round_sat(m[i][j], row.ovf);
      row.last = (i == 5);
      rows_due.push_back(row);
    end
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("row mismatch %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stm_row_t want;
    if (!rst_ni) begin
      mean_motion_q <= MEAN_MOTION_RST;
    end else begin
      // register writes; index other than mean motion is dropped
      if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_MEAN_MOTION)
        mean_motion_q <= pwdata;
      if (s_axis_tvalid && s_axis_tready) predict_matrix(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (rows_due.size() == 0) begin
          report("unexpected row", '0, {61'd0, m_axis_tdata[2:0]});
        end else begin
          want = rows_due.pop_front();
          if (m_axis_tdata[2:0] !== want.row)
            report("row_index", 64'(want.row), 64'(m_axis_tdata[2:0]));
          for (int j = 0; j < 6; j++)
            if (m_axis_tdata[3 + 64 * j +: 64] !== want.col[j])
              report($sformatf("row %0d col %0d", want.row, j), want.col[j],
                     m_axis_tdata[3 + 64 * j +: 64]);
          if (m_axis_tlast !== want.last)
            report("last_row", 64'(want.last), 64'(m_axis_tlast));
          if (m_axis_tuser[0] !== want.ovf)
            report("overflow", 64'(want.ovf), 64'(m_axis_tuser[0]));
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the CW transition matrix core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb import cwtm_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [0:0]             m_axis_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  int                     mismatch_cnt;
  int                     rows_pending;
  int                     idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  cw_transition_matrix_core DUT (.*);

  cwtm_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_cnt_o(mismatch_cnt),
    .rows_pending_o(rows_pending)
  );

  // Receiver: switch between free flow, random stalls and a fixed duty pattern
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (rx_tick % 5) != 0;
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  int unsigned burst_left = 0;

  // Send one step time request; hold valid across back-to-back requests
  task automatic send_step(input logic [31:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drain the pipe so the register can change safely
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 65535);
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return {8'($urandom_range(0, 255)), 24'd0} | 32'($urandom_range(0, 255));
    endcase
  endfunction

  // One register setting: write n, a few directed steps, then random steps
  task automatic run_phase(input logic [31:0] n, input int nrand, input bit first);
    if (!first) wait_idle();
    apb_write(3'd0, n);
    send_step(32'd0);
    send_step(32'd1);
    send_step(32'hFFFFFFFF);
    send_step(32'h80000000);
    repeat (nrand) send_step(rand_step());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset value of n first, including the odd steps near a quarter orbit
    send_step(32'd0);
    send_step(32'hFFFFFFFF);
    send_step(32'd300000);
    send_step(32'd18000);
    send_step(32'h55555555);
    send_step(32'hAAAAAAAA);
    repeat (15) send_step(rand_step());
    // write to an unmapped register: must change nothing
    wait_idle();
    apb_write(3'd4, $urandom);
    run_phase(32'd1, 20, 1'b1);
    run_phase(32'hFFFFFFFF, 20, 1'b0);
    run_phase(32'h80000000, 20, 1'b0);
    run_phase($urandom, 20, 1'b0);
    run_phase($urandom_range(1, 32'h00FFFFFF), 20, 1'b0);
    run_phase(MEAN_MOTION_RST, 15, 1'b0);
    wait_idle();
    if (mismatch_cnt == 0 && rows_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
